// ----- rtl/core/ookpwm_pkg.sv -----
// Shared types, widths and reset constants of the OOK pulse-width code decoder.
package ookpwm_pkg;

  localparam int DUR_W      = 21;
  localparam int NOM_W      = 16;
  localparam int PCT_W      = 7;
  localparam int MINB_W     = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int DEF_CODE_BITS   = 12;
  localparam int DEF_QUEUE_DEPTH = 8;

  // nominal * percent fits 23 bits; tolerance = product / 100 by reciprocal
  localparam int PROD_W    = NOM_W + PCT_W;
  localparam int RECIP_W   = 24;
  localparam int TOL_SHIFT = 30;
  localparam logic [RECIP_W-1:0] TOL_RECIP = 24'd10737419;
  localparam int QUOT_W    = PROD_W + RECIP_W;
  localparam int TOL_W     = 17;
  localparam int BND_W     = 19;

  localparam int RST_SHORT_NOM = 320;
  localparam int RST_LONG_NOM  = 640;
  localparam int RST_TOL_PCT   = 40;
  localparam int RST_MIN_BITS  = 8;
  localparam int RST_SHORT_TOL = RST_SHORT_NOM * RST_TOL_PCT / 100;
  localparam int RST_LONG_TOL  = RST_LONG_NOM * RST_TOL_PCT / 100;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SHORT_NOM = 2'd0,
    CFG_LONG_NOM  = 2'd1,
    CFG_TOL_PCT   = 2'd2,
    CFG_MIN_BITS  = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    OC_RUN  = 2'd0,
    OC_OK   = 2'd1,
    OC_FAIL = 2'd2
  } outcome_e;

  typedef struct packed {
    logic signed [BND_W-1:0] short_lo;
    logic signed [BND_W-1:0] short_hi;
    logic signed [BND_W-1:0] long_lo;
    logic signed [BND_W-1:0] long_hi;
  } bounds_t;

  typedef struct packed {
    logic neg;
    logic is_short;
    logic is_long;
    logic first;
    logic last;
  } item_t;

endpackage

// ----- rtl/core/ookpwm_if.sv -----
// Valid/ready channel interfaces for duration items and decode results.
interface ookpwm_in_if;
  import ookpwm_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [DUR_W-1:0] duration_us;
  logic                    first_of_capture;
  logic                    last_of_capture;

  modport source (output valid, duration_us, first_of_capture, last_of_capture, input ready);
  modport sink   (input valid, duration_us, first_of_capture, last_of_capture, output ready);
endinterface

interface ookpwm_out_if #(
  parameter int CODE_BITS = ookpwm_pkg::DEF_CODE_BITS
);
  logic                 valid;
  logic                 ready;
  logic                 found;
  logic [CODE_BITS-1:0] code;

  modport source (output valid, found, code, input ready);
  modport sink   (input valid, found, code, output ready);
endinterface

// ----- rtl/core/ookpwm_cfg.sv -----
// Configuration registers and the pipeline that derives the match windows.
module ookpwm_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [ookpwm_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [ookpwm_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output ookpwm_pkg::bounds_t                 bounds_o,
  output logic [ookpwm_pkg::MINB_W-1:0]       min_bits_o
);
  import ookpwm_pkg::*;

  logic [NOM_W-1:0]  short_q, long_q;
  logic [PCT_W-1:0]  pct_q;
  logic [MINB_W-1:0] minb_q;
  logic [PROD_W-1:0] prod_s_q, prod_l_q, prod_s_d, prod_l_d;
  logic [QUOT_W-1:0] quot_s, quot_l;
  logic [TOL_W-1:0]  tol_s_q, tol_l_q, tol_s_d, tol_l_d;
  bounds_t           bounds_q, bounds_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_q <= NOM_W'(RST_SHORT_NOM);
      long_q  <= NOM_W'(RST_LONG_NOM);
      pct_q   <= PCT_W'(RST_TOL_PCT);
      minb_q  <= MINB_W'(RST_MIN_BITS);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_SHORT_NOM: short_q <= cfg_data_i[NOM_W-1:0];
        CFG_LONG_NOM:  long_q  <= cfg_data_i[NOM_W-1:0];
        CFG_TOL_PCT:   pct_q   <= cfg_data_i[PCT_W-1:0];
        CFG_MIN_BITS:  minb_q  <= cfg_data_i[MINB_W-1:0];
        default: ;
      endcase
    end
  end

  // product, then divide by 100, then window edges, each step in its own register
  assign prod_s_d = PROD_W'({{PCT_W{1'b0}}, short_q} * {{NOM_W{1'b0}}, pct_q});
  assign prod_l_d = PROD_W'({{PCT_W{1'b0}}, long_q} * {{NOM_W{1'b0}}, pct_q});
  assign quot_s   = {{RECIP_W{1'b0}}, prod_s_q} * {{PROD_W{1'b0}}, TOL_RECIP};
  assign quot_l   = {{RECIP_W{1'b0}}, prod_l_q} * {{PROD_W{1'b0}}, TOL_RECIP};
  assign tol_s_d  = quot_s[TOL_SHIFT +: TOL_W];
  assign tol_l_d  = quot_l[TOL_SHIFT +: TOL_W];

  always_comb begin
    bounds_d.short_lo = $signed({{(BND_W-NOM_W){1'b0}}, short_q})
                      - $signed({{(BND_W-TOL_W){1'b0}}, tol_s_q});
    bounds_d.short_hi = $signed({{(BND_W-NOM_W){1'b0}}, short_q})
                      + $signed({{(BND_W-TOL_W){1'b0}}, tol_s_q});
    bounds_d.long_lo  = $signed({{(BND_W-NOM_W){1'b0}}, long_q})
                      - $signed({{(BND_W-TOL_W){1'b0}}, tol_l_q});
    bounds_d.long_hi  = $signed({{(BND_W-NOM_W){1'b0}}, long_q})
                      + $signed({{(BND_W-TOL_W){1'b0}}, tol_l_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_s_q          <= PROD_W'(RST_SHORT_NOM * RST_TOL_PCT);
      prod_l_q          <= PROD_W'(RST_LONG_NOM * RST_TOL_PCT);
      tol_s_q           <= TOL_W'(RST_SHORT_TOL);
      tol_l_q           <= TOL_W'(RST_LONG_TOL);
      bounds_q.short_lo <= BND_W'(RST_SHORT_NOM - RST_SHORT_TOL);
      bounds_q.short_hi <= BND_W'(RST_SHORT_NOM + RST_SHORT_TOL);
      bounds_q.long_lo  <= BND_W'(RST_LONG_NOM - RST_LONG_TOL);
      bounds_q.long_hi  <= BND_W'(RST_LONG_NOM + RST_LONG_TOL);
    end else begin
      prod_s_q <= prod_s_d;
      prod_l_q <= prod_l_d;
      tol_s_q  <= tol_s_d;
      tol_l_q  <= tol_l_d;
      bounds_q <= bounds_d;
    end
  end

  assign bounds_o   = bounds_q;
  assign min_bits_o = minb_q;

endmodule

// ----- rtl/core/ookpwm_front.sv -----
// Front end: accepts durations, takes the magnitude and classifies it as short or long.
module ookpwm_front #(
  parameter int QUEUE_DEPTH = ookpwm_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  ookpwm_in_if.sink           dur_i,
  input  ookpwm_pkg::bounds_t bounds_i,
  input  logic                pop_i,
  output logic                push_o,
  output ookpwm_pkg::item_t   item_o
);
  import ookpwm_pkg::*;

  localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);

  logic [OCC_W-1:0]        occ_q, occ_d;
  logic                    accept;
  logic                    v0_q, v1_q, v2_q;
  logic signed [DUR_W-1:0] dur0_q;
  logic                    first0_q, last0_q;
  logic [DUR_W-1:0]        mag1_q, mag2_q, mag_d;
  logic                    neg1_q, neg2_q;
  logic                    first1_q, last1_q, first2_q, last2_q;

  function automatic logic in_window(logic [DUR_W-1:0] mag,
                                     logic signed [BND_W-1:0] lo,
                                     logic signed [BND_W-1:0] hi);
    logic signed [DUR_W:0] m;
    m = $signed({1'b0, mag});
    return (m >= (DUR_W+1)'(lo)) && (m <= (DUR_W+1)'(hi));
  endfunction

  // hold one credit per item between the port and the back end
  assign dur_i.ready = (occ_q < OCC_W'(QUEUE_DEPTH));
  assign accept      = dur_i.valid && dur_i.ready;
  assign occ_d       = occ_q + OCC_W'(accept) - OCC_W'(pop_i);

  assign mag_d = dur0_q[DUR_W-1] ? DUR_W'(-dur0_q) : dur0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
      v0_q  <= 1'b0;
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
    end else begin
      occ_q <= occ_d;
      v0_q  <= accept;
      v1_q  <= v0_q;
      v2_q  <= v1_q;
    end
  end

  // the extra stage lines the compare up with the window update after a write
  always_ff @(posedge clk_i) begin
    dur0_q   <= dur_i.duration_us;
    first0_q <= dur_i.first_of_capture;
    last0_q  <= dur_i.last_of_capture;
    mag1_q   <= mag_d;
    neg1_q   <= dur0_q[DUR_W-1];
    first1_q <= first0_q;
    last1_q  <= last0_q;
    mag2_q   <= mag1_q;
    neg2_q   <= neg1_q;
    first2_q <= first1_q;
    last2_q  <= last1_q;
  end

  assign push_o          = v2_q;
  assign item_o.neg      = neg2_q;
  assign item_o.is_short = in_window(mag2_q, bounds_i.short_lo, bounds_i.short_hi);
  assign item_o.is_long  = in_window(mag2_q, bounds_i.long_lo, bounds_i.long_hi);
  assign item_o.first    = first2_q;
  assign item_o.last     = last2_q;

  occ_bound_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= OCC_W'(QUEUE_DEPTH))
    else $error("front credit count above queue depth");

endmodule

// ----- rtl/core/ookpwm_fifo.sv -----
// Small register queue between the classifier and the decoder.
module ookpwm_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [WIDTH-1:0] data_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;

  function automatic logic [PTR_W-1:0] next_ptr(logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= next_ptr(wr_ptr_q);
      if (pop_i)  rd_ptr_q <= next_ptr(rd_ptr_q);
      cnt_q <= cnt_q + CNT_W'(push_i) - CNT_W'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= data_i;
  end

  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  no_overflow_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (cnt_q != CNT_W'(DEPTH)))
    else $error("push into full queue");

endmodule

// ----- rtl/core/ookpwm_back.sv -----
// Back end: pairs classified durations, shifts bits into the code, registers the result.
module ookpwm_back #(
  parameter int CODE_BITS = ookpwm_pkg::DEF_CODE_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          empty_i,
  input  ookpwm_pkg::item_t             head_i,
  input  logic [ookpwm_pkg::MINB_W-1:0] min_bits_i,
  output logic                          pop_o,
  ookpwm_out_if.source                  res_o
);
  import ookpwm_pkg::*;

  localparam int BITS_W = $clog2(CODE_BITS + 1);
  localparam int CMP_W  = (BITS_W > MINB_W) ? BITS_W : MINB_W;

  logic                 phase_q, phase_d;
  logic                 hneg_q, hneg_d, hshort_q, hshort_d, hlong_q, hlong_d;
  logic [CODE_BITS-1:0] shift_q, shift_d;
  logic [BITS_W-1:0]    bits_q, bits_d;
  outcome_e             outcome_q, outcome_d;
  logic                 at_start_q, at_start_d;
  logic                 skip, bit_val;
  logic                 res_valid_q, res_valid_d, found_q, found_d;
  logic [CODE_BITS-1:0] code_q, code_d;

  assign pop_o = !empty_i && (!head_i.last || !res_valid_q || res_o.ready);

  always_comb begin
    phase_d     = phase_q;
    hneg_d      = hneg_q;
    hshort_d    = hshort_q;
    hlong_d     = hlong_q;
    shift_d     = shift_q;
    bits_d      = bits_q;
    outcome_d   = outcome_q;
    at_start_d  = at_start_q;
    found_d     = found_q;
    code_d      = code_q;
    res_valid_d = res_valid_q && !res_o.ready;
    skip        = 1'b0;
    bit_val     = 1'b0;
    if (pop_o) begin
      if (head_i.first) begin
        phase_d    = 1'b0;
        shift_d    = '0;
        bits_d     = '0;
        outcome_d  = OC_RUN;
        at_start_d = 1'b1;
      end
      // drop a leading low level of a capture
      skip       = at_start_d && head_i.neg;
      at_start_d = 1'b0;
      if (!skip && outcome_d == OC_RUN) begin
        if (!phase_d) begin
          hneg_d   = head_i.neg;
          hshort_d = head_i.is_short;
          hlong_d  = head_i.is_long;
          phase_d  = 1'b1;
        end else begin
          phase_d = 1'b0;
          if (hneg_d) begin
            outcome_d = OC_FAIL;
          end else if ((hshort_d && head_i.is_long) || (hlong_d && head_i.is_short)) begin
            // short-long wins when both patterns match
            bit_val = !(hshort_d && head_i.is_long);
            shift_d = CODE_BITS'({shift_d, bit_val});
            bits_d  = bits_d + BITS_W'(1);
            if (bits_d == BITS_W'(CODE_BITS)) outcome_d = OC_OK;
          end else if (CMP_W'(bits_d) >= CMP_W'(min_bits_i)) begin
            outcome_d = OC_FAIL;
          end else begin
            shift_d = '0;
            bits_d  = '0;
          end
        end
      end
      if (head_i.last) begin
        found_d     = (outcome_d == OC_OK);
        code_d      = (outcome_d == OC_OK) ? shift_d : '0;
        res_valid_d = 1'b1;
        phase_d     = 1'b0;
        shift_d     = '0;
        bits_d      = '0;
        outcome_d   = OC_RUN;
        at_start_d  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= 1'b0;
      hneg_q      <= 1'b0;
      hshort_q    <= 1'b0;
      hlong_q     <= 1'b0;
      shift_q     <= '0;
      bits_q      <= '0;
      outcome_q   <= OC_RUN;
      at_start_q  <= 1'b1;
      res_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      hneg_q      <= hneg_d;
      hshort_q    <= hshort_d;
      hlong_q     <= hlong_d;
      shift_q     <= shift_d;
      bits_q      <= bits_d;
      outcome_q   <= outcome_d;
      at_start_q  <= at_start_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    found_q <= found_d;
    code_q  <= code_d;
  end

  assign res_o.valid = res_valid_q;
  assign res_o.found = found_q;
  assign res_o.code  = code_q;

  code_zero_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && !found_q) |-> (code_q == '0))
    else $error("code nonzero on a failed decode");

  ok_count_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (outcome_q == OC_OK) |-> (bits_q == BITS_W'(CODE_BITS)))
    else $error("decode success without a full bit count");

  bits_range_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bits_q <= BITS_W'(CODE_BITS))
    else $error("bit count beyond code length");

endmodule

// ----- rtl/core/ook_pwm_code_decoder_unit.sv -----
// Top level of the OOK pulse-width code decoder: config, classifier, queue and decoder.
// Result path: input, magnitude, queue and result registers. Throughput: one duration per
// cycle while credits last; the front credit counter allows QUEUE_DEPTH items ahead of the
// decoder, which retires one queued item per cycle unless a last item waits on a held result.
// Reset: asynchronous, active low; registers return to their defaults at once, the
// capture state clears and the next item opens a new capture. No clearing pass.
module ook_pwm_code_decoder_unit #(
  parameter int CODE_BITS   = ookpwm_pkg::DEF_CODE_BITS,
  parameter int QUEUE_DEPTH = ookpwm_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [ookpwm_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ookpwm_pkg::CFG_DATA_W-1:0] cfg_data_i,
  ookpwm_in_if.sink                         dur_i,
  ookpwm_out_if.source                      res_o
);
  import ookpwm_pkg::*;

  bounds_t           bounds;
  logic [MINB_W-1:0] min_bits;
  logic              push, pop, empty;
  item_t             item_in, item_head;

  ookpwm_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .bounds_o   (bounds),
    .min_bits_o (min_bits)
  );

  ookpwm_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .dur_i    (dur_i),
    .bounds_i (bounds),
    .pop_i    (pop),
    .push_o   (push),
    .item_o   (item_in)
  );

  ookpwm_fifo #(
    .WIDTH ($bits(item_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (item_in),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (item_head)
  );

  ookpwm_back #(
    .CODE_BITS (CODE_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .empty_i    (empty),
    .head_i     (item_head),
    .min_bits_i (min_bits),
    .pop_o      (pop),
    .res_o      (res_o)
  );

endmodule

// ----- bench/ookpwm_decode_checker.sv -----
// Checker for the OOK decoder: predicts the 12-bit code of each capture and compares results.
`timescale 1ns / 100ps

module ookpwm_decode_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [ookpwm_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ookpwm_pkg::CFG_DATA_W-1:0] cfg_data_i,
  ookpwm_in_if                              dur_mon,
  ookpwm_out_if                             res_mon,
  output int                                err_cnt_o,
  output int                                pending_o
);
  import ookpwm_pkg::*;

  localparam int CODE_BITS = DEF_CODE_BITS;

  typedef struct packed {
    logic                 found;
    logic [CODE_BITS-1:0] code;
  } decode_res_t;

  // register copies
  logic [NOM_W-1:0]  short_nom;
  logic [NOM_W-1:0]  long_nom;
  logic [PCT_W-1:0]  tol_pct;
  logic [MINB_W-1:0] min_bits;

  // capture state
  bit                   pair_half;
  int                   held_pulse;
  logic [CODE_BITS-1:0] shift_code;
  int                   bit_cnt;
  outcome_e             outcome;
  bit                   fresh_capture;

  decode_res_t code_expect_q[$];
  int          mismatch_cnt = 0;
  int          result_idx   = 0;
  int          pending_cnt  = 0;

  assign err_cnt_o = mismatch_cnt;
  assign pending_o = pending_cnt;

  function automatic bit in_window(int mag, int nom);
    int tol;
    tol = nom * int'(tol_pct) / 100;
    return (mag >= nom - tol) && (mag <= nom + tol);
  endfunction

  function automatic void clear_capture();
    pair_half     = 1'b0;
    held_pulse    = 0;
    shift_code    = '0;
    bit_cnt       = 0;
    outcome       = OC_RUN;
    fresh_capture = 1'b1;
  endfunction

  function automatic void score_pair(int pulse, int gap);
    int gap_mag;
    bit code_bit;
    if (pulse < 0) begin
      outcome = OC_FAIL;
      return;
    end
    gap_mag = (gap < 0) ? -gap : gap;
    if (in_window(pulse, int'(short_nom)) && in_window(gap_mag, int'(long_nom))) begin
      code_bit = 1'b0;
    end else if (in_window(pulse, int'(long_nom)) && in_window(gap_mag, int'(short_nom))) begin
      code_bit = 1'b1;
    end else begin
      // late garbage kills the decode, early garbage only restarts it
      if (bit_cnt >= int'(min_bits)) begin
        outcome = OC_FAIL;
      end else begin
        shift_code = '0;
        bit_cnt    = 0;
      end
      return;
    end
    shift_code = {shift_code[CODE_BITS-2:0], code_bit};
    bit_cnt++;
    if (bit_cnt >= CODE_BITS) outcome = OC_OK;
  endfunction

  function automatic bit decode_step(int dur, bit first, bit last, output decode_res_t res);
    bit skip;
    skip = 1'b0;
    res  = '0;
    if (first) clear_capture();
    if (fresh_capture) begin
      fresh_capture = 1'b0;
      if (dur < 0) skip = 1'b1;
    end
    if (!skip && outcome == OC_RUN) begin
      if (!pair_half) begin
        held_pulse = dur;
        pair_half  = 1'b1;
      end else begin
        pair_half = 1'b0;
        score_pair(held_pulse, dur);
      end
    end
    if (last) begin
      res.found = (outcome == OC_OK);
      res.code  = res.found ? shift_code : '0;
      clear_capture();
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void flag_error(string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) $display("[%0t] ERROR: %s", $realtime, msg);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    decode_res_t exp_r;
    decode_res_t got_r;
    if (!rst_ni) begin
      short_nom = NOM_W'(RST_SHORT_NOM);
      long_nom  = NOM_W'(RST_LONG_NOM);
      tol_pct   = PCT_W'(RST_TOL_PCT);
      min_bits  = MINB_W'(RST_MIN_BITS);
      clear_capture();
      code_expect_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SHORT_NOM: short_nom = cfg_data_i[NOM_W-1:0];
          CFG_LONG_NOM:  long_nom  = cfg_data_i[NOM_W-1:0];
          CFG_TOL_PCT:   tol_pct   = cfg_data_i[PCT_W-1:0];
          CFG_MIN_BITS:  min_bits  = cfg_data_i[MINB_W-1:0];
          default: ;
        endcase
      end
      if (dur_mon.valid && dur_mon.ready) begin
        if (decode_step(int'(dur_mon.duration_us), dur_mon.first_of_capture,
                        dur_mon.last_of_capture, exp_r)) begin
          code_expect_q.push_back(exp_r);
        end
      end
      if (res_mon.valid && res_mon.ready) begin
        got_r.found = res_mon.found;
        got_r.code  = res_mon.code;
        if (code_expect_q.size() == 0) begin
          flag_error($sformatf("result %0d with no capture pending: found=%0b code=%03h",
                               result_idx, got_r.found, got_r.code));
        end else begin
          exp_r = code_expect_q.pop_front();
          if (got_r.found !== exp_r.found || got_r.code !== exp_r.code) begin
            flag_error($sformatf("result %0d: expected found=%0b code=%03h, got found=%0b code=%03h",
                                 result_idx, exp_r.found, exp_r.code, got_r.found, got_r.code));
          end
        end
        result_idx++;
      end
    end
    pending_cnt = code_expect_q.size();
  end

endmodule

// ----- bench/tb_top.sv -----
// Top of the OOK decoder bench: clock, reset, register setup, capture stimulus and verdict.
`timescale 1ns / 100ps

module tb_top;
  import ookpwm_pkg::*;

  localparam int CODE_BITS       = DEF_CODE_BITS;
  localparam int NUM_PHASES      = 8;
  localparam int RANDOM_ITEMS    = 1500;
  localparam int STALL_LIMIT     = 3000;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int HOLD_AT_RESULT  = 30;
  localparam int SETTLE_CYCLES   = 8;
  localparam int DRAIN_CYCLES    = 20;

  typedef enum {
    BURST_CLEAN,
    BURST_BAD_PAIR,
    BURST_NEG_PULSE,
    BURST_SHORT,
    BURST_NOISE
  } burst_kind_e;

  typedef struct {
    int dur;
    bit first;
    bit last;
  } dur_item_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  ookpwm_in_if                              dur_if ();
  ookpwm_out_if #(.CODE_BITS(CODE_BITS))    res_if ();

  int err_cnt;
  int pending_cnt;
  int quiet_cycles = 0;
  int results_taken = 0;
  int items_sent = 0;
  bit src_idle_en = 1'b1;
  bit snk_idle_en = 1'b1;

  // bench copy of the register values, used to aim durations at the windows
  int short_nom = RST_SHORT_NOM;
  int long_nom  = RST_LONG_NOM;
  int tol_pct   = RST_TOL_PCT;

  dur_item_t burst_q[$];

  ook_pwm_code_decoder_unit #(
    .CODE_BITS (CODE_BITS)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .dur_i      (dur_if),
    .res_o      (res_if)
  );

  ookpwm_decode_checker i_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .dur_mon    (dur_if),
    .res_mon    (res_if),
    .err_cnt_o  (err_cnt),
    .pending_o  (pending_cnt)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (dur_if.valid && dur_if.ready) || (res_if.valid && res_if.ready) || cfg_we_i) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result side: random stalls, one long hold-off to back up the input
  initial begin
    int stall;
    res_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = snk_idle_en ? $urandom_range(0, 19) : 0;
      if (results_taken == HOLD_AT_RESULT) stall = HOLD_OFF_CYCLES;
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk_i); while (!res_if.valid);
      results_taken++;
    end
  end

  function automatic int in_win(int nom);
    int tol, lo, hi;
    tol = nom * tol_pct / 100;
    lo  = (nom - tol < 0) ? 0 : nom - tol;
    hi  = nom + tol;
    case ($urandom_range(0, 3))
      0:       return lo;
      1:       return hi;
      default: return $urandom_range(hi, lo);
    endcase
  endfunction

  function automatic int off_win(int nom);
    int tol, lo;
    tol = nom * tol_pct / 100;
    lo  = nom - tol;
    if (lo > 1 && $urandom_range(0, 1)) return lo - $urandom_range(1, (lo - 1 < 50) ? lo - 1 : 50);
    return nom + tol + $urandom_range(1, 50);
  endfunction

  // gaps are low level most of the time
  function automatic int as_gap(int mag);
    return ($urandom_range(0, 4) != 0) ? -mag : mag;
  endfunction

  function automatic void push_item(int d, bit f, bit l);
    burst_q.push_back('{dur: d, first: f, last: l});
  endfunction

  function automatic void push_bit_pair(bit b);
    push_item(in_win(b ? long_nom : short_nom), 1'b0, 1'b0);
    push_item(as_gap(in_win(b ? short_nom : long_nom)), 1'b0, 1'b0);
  endfunction

  function automatic void build_burst(burst_kind_e kind, bit close);
    logic [CODE_BITS-1:0]    code;
    logic signed [DUR_W-1:0] raw;
    int                      fault_at;
    int                      n;
    code     = CODE_BITS'($urandom);
    fault_at = $urandom_range(0, CODE_BITS - 1);
    if (kind == BURST_NOISE) begin
      n = $urandom_range(1, 30);
      repeat (n) begin
        raw = DUR_W'($urandom);
        push_item(int'(raw), $urandom_range(0, 15) == 0, 1'b0);
      end
    end else begin
      if ($urandom_range(0, 1)) push_item(-in_win(long_nom), 1'b0, 1'b0);
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 3)) begin
          push_item(off_win(short_nom), 1'b0, 1'b0);
          push_item(as_gap(off_win(short_nom)), 1'b0, 1'b0);
        end
      end
      for (int i = CODE_BITS - 1; i >= 0; i--) begin
        if (kind == BURST_BAD_PAIR && i == fault_at) begin
          push_item(off_win(long_nom), 1'b0, 1'b0);
          push_item(as_gap(off_win(long_nom)), 1'b0, 1'b0);
        end
        if (kind == BURST_NEG_PULSE && i == fault_at) begin
          push_item(-in_win(short_nom), 1'b0, 1'b0);
          push_item(as_gap(in_win(long_nom)), 1'b0, 1'b0);
        end else begin
          push_bit_pair(code[i]);
        end
      end
      repeat ($urandom_range(0, 2)) push_bit_pair($urandom_range(0, 1));
      // unpaired tail
      if ($urandom_range(0, 2) == 0) push_item(as_gap(in_win(short_nom)), 1'b0, 1'b0);
      if (kind == BURST_SHORT) begin
        n = $urandom_range(1, 21);
        while (burst_q.size() > n) void'(burst_q.pop_back());
      end
    end
    burst_q[0].first                = ($urandom_range(0, 3) != 0);
    burst_q[burst_q.size() - 1].last = close;
  endfunction

  task automatic send_item(dur_item_t it);
    int gap;
    gap = src_idle_en ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      dur_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    dur_if.valid            <= 1'b1;
    dur_if.duration_us      <= DUR_W'(it.dur);
    dur_if.first_of_capture <= it.first;
    dur_if.last_of_capture  <= it.last;
    do @(posedge clk_i); while (!dur_if.ready);
  endtask

  task automatic flush_burst();
    foreach (burst_q[i]) send_item(burst_q[i]);
    items_sent += burst_q.size();
    burst_q.delete();
  endtask

  // drop valid, let every result come back, then let the pipeline settle
  task automatic wait_idle();
    dur_if.valid <= 1'b0;
    do @(negedge clk_i); while (pending_cnt != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, int val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= CFG_DATA_W'(val);
    @(posedge clk_i);
  endtask

  task automatic set_config(int s_nom, int l_nom, int pct, int min_b);
    write_reg(CFG_SHORT_NOM, s_nom);
    write_reg(CFG_LONG_NOM, l_nom);
    write_reg(CFG_TOL_PCT, pct);
    write_reg(CFG_MIN_BITS, min_b);
    cfg_we_i  <= 1'b0;
    short_nom = s_nom;
    long_nom  = l_nom;
    tol_pct   = pct;
    @(posedge clk_i);
  endtask

  initial begin
    logic [CODE_BITS-1:0] dir_code;
    int                   s_nom;
    int                   pick;
    int                   phase_budget;
    bit                   close;
    burst_kind_e          kind;

    rst_ni                  <= 1'b0;
    cfg_we_i                <= 1'b0;
    cfg_idx_i               <= CFG_SHORT_NOM;
    cfg_data_i              <= '0;
    dur_if.valid            <= 1'b0;
    dur_if.duration_us      <= '0;
    dur_if.first_of_capture <= 1'b0;
    dur_if.last_of_capture  <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // one-item captures at the extremes, one with no first mark
    push_item(1048575, 1'b1, 1'b1);
    push_item(-1048576, 1'b1, 1'b1);
    push_item(0, 1'b0, 1'b1);
    // clean code with a leading low level and an unpaired tail
    dir_code = 12'hA5C;
    push_item(-700, 1'b1, 1'b0);
    for (int i = CODE_BITS - 1; i >= 0; i--) push_bit_pair(dir_code[i]);
    push_item(-5, 1'b0, 1'b1);
    flush_burst();
    wait_idle();
    items_sent = 0;

    phase_budget = RANDOM_ITEMS / NUM_PHASES;
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: set_config(1, 2, 0, 0);
        1: set_config(65535, 30000, 100, 12);
        2: set_config(300, 900, 127, 15);
        3: set_config(200, 600, 35, 4);
        default: begin
          s_nom = $urandom_range(50, 3000);
          set_config(s_nom, s_nom * $urandom_range(2, 4), $urandom_range(0, 60),
                     $urandom_range(0, 13));
        end
      endcase
      src_idle_en = (ph % 4 == 0) || (ph % 4 == 2);
      snk_idle_en = (ph % 4 == 0) || (ph % 4 == 3);
      close = 1'b1;
      while (items_sent < (ph + 1) * phase_budget) begin
        pick = $urandom_range(0, 19);
        if (pick <= 10)      kind = BURST_CLEAN;
        else if (pick <= 13) kind = BURST_BAD_PAIR;
        else if (pick <= 15) kind = BURST_NEG_PULSE;
        else if (pick == 16) kind = BURST_SHORT;
        else                 kind = BURST_NOISE;
        // leave a capture open now and then so it runs into the next one
        close = ($urandom_range(0, 9) != 0);
        build_burst(kind, close);
        flush_burst();
      end
      if (!close) begin
        push_item(0, 1'b0, 1'b1);
        flush_burst();
      end
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    if (err_cnt == 0 && pending_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
